/* hdl/rom_bank_slot_cache_assert.svh */
// Assertion macros for the bank slot cache.
// IMP: implication in the same cycle. NXT: implication in the next cycle.
`ifndef ROM_BANK_SLOT_CACHE_ASSERT_SVH
`define ROM_BANK_SLOT_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define RBSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RBSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RBSC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RBSC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/rbsc_pkg.sv */
`timescale 1ns / 1ps
package rbsc_pkg;

  // Defaults for the top level parameters
  localparam int SLOT_COUNT_DEF = 4;
  localparam int BANK_BITS_DEF  = 9;

  // Fixed payload widths
  localparam int BANK_IN_W  = 9;
  localparam int SLOT_OUT_W = 2;
  localparam int COUNT_W    = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // Control from the pipeline to the slot array
  typedef struct packed {
    logic go;           // item in the input stage moves on this cycle
    logic flush;        // flush command held in the input stage
    logic lookup;       // lookup of a nonzero bank held in the input stage
    logic rom_present;  // fills and flushes allowed
  } rbsc_ctl_t;

endpackage

/* hdl/rbsc_if.sv */
`timescale 1ns / 1ps
// Request channel: one command word per handshake
interface rbsc_req_if import rbsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [BANK_IN_W-1:0] bank;

  modport source (output valid, cmd, bank, input ready);
  modport sink   (input valid, cmd, bank, output ready);
endinterface

// Response channel: one result word per handshake
interface rbsc_rsp_if import rbsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  fixed_bank;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  fill_needed;
  logic [COUNT_W-1:0]    hit_total;
  logic [COUNT_W-1:0]    miss_total;

  modport source (output valid, fixed_bank, hit, slot, fill_needed, hit_total, miss_total,
                  input ready);
  modport sink   (input valid, fixed_bank, hit, slot, fill_needed, hit_total, miss_total,
                  output ready);
endinterface

/* hdl/rbsc_victim.sv */
`timescale 1ns / 1ps
// Replacement pick: first empty slot, else lowest use count, lowest index on ties.
// Compare tree over key {occupied, count}; empty slots always carry count zero.
module rbsc_victim import rbsc_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int SLOT_W     = 2
) (
  input  logic [SLOT_COUNT-1:0] empty,
  input  logic [COUNT_W-1:0]    count [SLOT_COUNT],
  output logic [SLOT_W-1:0]     victim
);

  localparam int LEAVES = 1 << SLOT_W;
  localparam int KEY_W  = COUNT_W + 1;

  logic [KEY_W-1:0]  key [1:2*LEAVES-1];
  logic [SLOT_W-1:0] idx [1:2*LEAVES-1];
  logic              vld [1:2*LEAVES-1];

  // Leaves; padding leaves never win
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < SLOT_COUNT) begin : g_used
      assign key[LEAVES+i] = {~empty[i], count[i]};
      assign vld[LEAVES+i] = 1'b1;
    end else begin : g_pad
      assign key[LEAVES+i] = '0;
      assign vld[LEAVES+i] = 1'b0;
    end
    assign idx[LEAVES+i] = SLOT_W'(i);
  end

  // Inner nodes: right side wins only on a strictly lower key
  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    logic pick_r;
    assign pick_r = vld[2*n+1] && (!vld[2*n] || (key[2*n+1] < key[2*n]));
    assign key[n] = pick_r ? key[2*n+1] : key[2*n];
    assign idx[n] = pick_r ? idx[2*n+1] : idx[2*n];
    assign vld[n] = vld[2*n] | vld[2*n+1];
  end

  assign victim = idx[1];

endmodule

/* hdl/rbsc_slots.sv */
`timescale 1ns / 1ps
// Slot array: tags, use counts, parallel tag match and the update on each item.
module rbsc_slots import rbsc_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int BANK_BITS  = BANK_BITS_DEF,
  parameter int SLOT_W     = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rbsc_ctl_t            ctl,
  input  logic [BANK_BITS-1:0] bank,
  output logic                 hit,
  output logic [SLOT_W-1:0]    hit_idx,
  output logic [SLOT_W-1:0]    victim
);

  logic [BANK_BITS-1:0]  tag   [SLOT_COUNT];
  logic [COUNT_W-1:0]    count [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] empty;
  logic [COUNT_W-1:0]    hit_count_next;

  // Parallel tag compare, lowest matching index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (tag[i] == bank) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      empty[i] = (tag[i] == '0);
    end
  end

  rbsc_victim #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_victim (
    .empty  (empty),
    .count  (count),
    .victim (victim)
  );

  // Saturating use count of the hit slot
  assign hit_count_next = (count[hit_idx] != COUNT_MAX) ? count[hit_idx] + COUNT_W'(1)
                                                        : count[hit_idx];

  // Flush, hit bump or fill of the victim
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tag[i]   <= '0;
        count[i] <= '0;
      end
    end else if (ctl.go) begin
      if (ctl.flush && ctl.rom_present) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          tag[i]   <= '0;
          count[i] <= '0;
        end
      end else if (ctl.lookup && hit) begin
        count[hit_idx] <= hit_count_next;
      end else if (ctl.lookup && ctl.rom_present) begin
        tag[victim]   <= bank;
        count[victim] <= COUNT_W'(1);
      end
    end
  end

endmodule

/* hdl/rom_bank_slot_cache.sv */
`timescale 1ns / 1ps
// ROM bank slot cache: fully associative map of ROM banks onto buffer slots,
// least-frequently-used replacement.
// Channels: req (sink) takes a command word {cmd, bank}; cmd 0 looks up a bank,
// cmd 1 flushes every slot while rom_present is 1. rsp (source) returns one result word per request:
// fixed_bank, hit, slot, fill_needed and the running hit and miss totals.
// cfg_wr_en/cfg_wr_data write rom_present; write it only while the block is idle.
// Path: a request is held in the input register, then tag match, victim pick and
// slot update run combinationally from it into the result register, which
// presents the result word.
// Throughput is one word per cycle while rsp is not held off; the limit is the
// combinational path through the tag compare and the use-count compare tree.
// Stall: while rsp is held off the result register keeps its word and the input
// register fills; req.ready drops once both are occupied.
// Reset (rst, synchronous): slots empty, counts and totals zero, rom_present 0,
// both channels empty. Ready is high in the first cycle after reset.
`include "rom_bank_slot_cache_assert.svh"
module rom_bank_slot_cache import rbsc_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int BANK_BITS  = BANK_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rbsc_req_if.sink   req,
  rbsc_rsp_if.source rsp,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic                 rom_present;
  logic                 s1_valid;
  logic                 s1_cmd;
  logic [BANK_BITS-1:0] s1_bank;
  logic                 rsp_valid;
  logic [COUNT_W-1:0]   hits;
  logic [COUNT_W-1:0]   misses;
  logic [COUNT_W-1:0]   hits_next;
  logic [COUNT_W-1:0]   misses_next;
  logic                 adv;
  logic                 s1_go;
  logic                 is_fixed;
  logic                 is_hit;
  logic                 is_miss;
  logic [SLOT_W-1:0]    slot_sel;
  rbsc_ctl_t            ctl;
  logic                 slot_hit;
  logic [SLOT_W-1:0]    hit_idx;
  logic [SLOT_W-1:0]    victim;

  // Handshake: result register frees, then input register frees
  assign adv       = !rsp_valid || rsp.ready;
  assign s1_go     = s1_valid && adv;
  assign req.ready = !s1_valid || adv;
  assign rsp.valid = rsp_valid;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_present <= 1'b0;
    end else if (cfg_wr_en) begin
      rom_present <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_cmd  <= req.cmd;
      s1_bank <= BANK_BITS'(req.bank);
    end
  end

  // Decode of the held word
  assign ctl.go          = s1_go;
  assign ctl.flush       = s1_valid && (s1_cmd == CMD_FLUSH);
  assign ctl.lookup      = s1_valid && (s1_cmd == CMD_LOOKUP) && (s1_bank != '0);
  assign ctl.rom_present = rom_present;

  assign is_fixed = (s1_cmd == CMD_LOOKUP) && (s1_bank == '0);
  assign is_hit   = ctl.lookup && slot_hit;
  assign is_miss  = ctl.lookup && !slot_hit;
  assign slot_sel = is_hit ? hit_idx : (is_miss ? victim : '0);

  rbsc_slots #(
    .SLOT_COUNT (SLOT_COUNT),
    .BANK_BITS  (BANK_BITS),
    .SLOT_W     (SLOT_W)
  ) u_slots (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .bank    (s1_bank),
    .hit     (slot_hit),
    .hit_idx (hit_idx),
    .victim  (victim)
  );

  // Hit and miss totals
  assign hits_next   = hits + COUNT_W'(is_hit);
  assign misses_next = misses + COUNT_W'(is_miss);

  always_ff @(posedge clk) begin
    if (rst) begin
      hits      <= '0;
      misses    <= '0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s1_valid;
      if (s1_valid) begin
        hits   <= hits_next;
        misses <= misses_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_go) begin
      rsp.fixed_bank  <= is_fixed;
      rsp.hit         <= is_hit;
      rsp.slot        <= SLOT_OUT_W'(slot_sel);
      rsp.fill_needed <= is_miss && rom_present;
      rsp.hit_total   <= hits_next;
      rsp.miss_total  <= misses_next;
    end
  end

  // Checks
  `RBSC_ASSERT_IMP(a_fill_on_miss, clk, rst, rsp.valid && rsp.fill_needed, !rsp.hit && !rsp.fixed_bank, "fill requested on a hit or fixed bank")
  `RBSC_ASSERT_NXT(a_hit_total, clk, rst, s1_go && is_hit, hits == $past(hits) + COUNT_W'(1), "hit total did not advance on a hit")
  `RBSC_ASSERT_NXT(a_miss_total, clk, rst, s1_go && !is_miss, misses == $past(misses), "miss total moved without a miss")

endmodule
